### design/tts_pkg.sv
// Package for the timestamp text scanner: widths, codes, character constants,
// the verdict queue entry type and the fraction scale table. No dependencies.
package tts_pkg;

	// Fixed widths of the payload fields and of the internal values.
	localparam int STATUS_W   = 3;
	localparam int USED_W     = 11;
	localparam int TIME_W     = 62;
	localparam int FIELD_W    = 30;
	localparam int FRAC_W     = 20;
	localparam int FRAC_CNT_W = 3;

	// Defaults of the top-level parameters.
	localparam int MAX_LINE_LEN_DEF = 1024;
	localparam int FIELD_DIGITS_DEF = 9;
	localparam int FRAC_DIGITS_DEF  = 6;

	// Depth of the verdict queue between front and back.
	localparam int QUEUE_DEPTH = 2;

	// Range limit for minutes and seconds.
	localparam logic [FIELD_W-1:0] SEXA_LIMIT = FIELD_W'(60);

	// Microseconds per unit.
	localparam logic [31:0] HOUR_US = 32'd3600000000;
	localparam logic [25:0] MIN_US  = 26'd60000000;
	localparam logic [19:0] SEC_US  = 20'd1000000;

	// Characters.
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_BAD_FIELD = 3'd1,
		ST_SINGLE    = 3'd2,
		ST_BAD_TERM  = 3'd3,
		ST_MIN       = 3'd4,
		ST_SEC       = 3'd5,
		ST_OVERLONG  = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		PH_FIELD_START,
		PH_IN_FIELD,
		PH_FRAC_START,
		PH_IN_FRAC
	} phase_t;

	// One verdict as decided by the front; the back turns it into microseconds.
	typedef struct packed {
		status_t                status;
		logic [USED_W-1:0]      used;
		logic [FIELD_W-1:0]     hours;
		logic [FIELD_W-1:0]     minutes;
		logic [FIELD_W-1:0]     seconds;
		logic [FRAC_W-1:0]      frac;
		logic [FRAC_CNT_W-1:0]  frac_digits;
	} verdict_t;

	// Scale of a kept fraction with the given digit count, in microseconds.
	function automatic logic [FRAC_W-1:0] frac_scale(input logic [FRAC_CNT_W-1:0] fd);
		logic [FRAC_W-1:0] r;
		unique case (fd)
			3'd0:    r = FRAC_W'(1000000);
			3'd1:    r = FRAC_W'(100000);
			3'd2:    r = FRAC_W'(10000);
			3'd3:    r = FRAC_W'(1000);
			3'd4:    r = FRAC_W'(100);
			3'd5:    r = FRAC_W'(10);
			default: r = FRAC_W'(1);
		endcase
		return r;
	endfunction

endpackage

### design/tts_in_if.sv
// Character channel of the timestamp text scanner: valid, ready, one character.
// Depends on tts_pkg only through nothing; widths are those of a raw byte.
interface tts_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       line_end;

	modport source(output valid, text_byte, line_end, input ready);
	modport sink(input valid, text_byte, line_end, output ready);
endinterface

### design/tts_out_if.sv
// Verdict channel of the timestamp text scanner: valid, ready, one verdict.
// Depends on tts_pkg for the field widths.
interface tts_out_if;
	logic                         valid;
	logic                         ready;
	logic [tts_pkg::STATUS_W-1:0] status;
	logic [tts_pkg::USED_W-1:0]   used_length;
	logic [tts_pkg::TIME_W-1:0]   time_us;

	modport source(output valid, status, used_length, time_us, input ready);
	modport sink(input valid, status, used_length, time_us, output ready);
endinterface

### design/tts_front.sv
// Front of the timestamp text scanner: takes characters, runs the parse state
// machine and decides each line's verdict. Depends on tts_pkg and tts_in_if.
module tts_front #(
	parameter int MAX_LINE_LEN = tts_pkg::MAX_LINE_LEN_DEF,
	parameter int FIELD_DIGITS = tts_pkg::FIELD_DIGITS_DEF,
	parameter int FRAC_DIGITS  = tts_pkg::FRAC_DIGITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	tts_in_if.sink            chars,
	input  logic              q_full,
	output logic              push,
	output tts_pkg::verdict_t entry
);

	localparam int CNT_W = $clog2(MAX_LINE_LEN + 1);
	localparam int DC_W  = $clog2(FIELD_DIGITS + 1);
	localparam int FW    = tts_pkg::FIELD_W;
	localparam int AW    = tts_pkg::FRAC_W;
	localparam int NW    = tts_pkg::FRAC_CNT_W;

	tts_pkg::phase_t phase_q, phase_n;
	logic [1:0]      fcnt_q, fcnt_n;
	logic [DC_W-1:0] dcnt_q, dcnt_n;
	logic [FW-1:0]   fv_q [3];
	logic [FW-1:0]   fv_n [3];
	logic [AW-1:0]   facc_q, facc_n;
	logic [NW-1:0]   fdig_q, fdig_n;
	logic [CNT_W-1:0] cons_q, cons_n;
	logic            given_q, given_n;

	logic            xfer;
	logic            is_digit;
	logic [3:0]      dval;
	logic            is_blank;
	logic            is_mark;
	logic [1:0]      k;
	logic [1:0]      fc1;

	// Decision of the current character.
	logic              emit;
	logic              fin;
	logic              three;
	tts_pkg::status_t  fail_st;

	assign chars.ready = !q_full;
	assign xfer        = chars.valid && chars.ready;
	assign is_digit    = chars.text_byte >= tts_pkg::CH_ZERO &&
	                     chars.text_byte <= tts_pkg::CH_NINE;
	assign dval        = 4'(chars.text_byte - tts_pkg::CH_ZERO);
	assign is_blank    = chars.text_byte == tts_pkg::CH_SPACE ||
	                     chars.text_byte == tts_pkg::CH_TAB;
	assign is_mark     = chars.text_byte == tts_pkg::CH_DOT ||
	                     chars.text_byte == tts_pkg::CH_COMMA;
	assign k           = (fcnt_q > 2'd2) ? 2'd2 : fcnt_q;
	assign fc1         = fcnt_q + 2'd1;

	// Next state.
	always_comb begin
		phase_n = phase_q;
		fcnt_n  = fcnt_q;
		dcnt_n  = dcnt_q;
		fv_n    = fv_q;
		facc_n  = facc_q;
		fdig_n  = fdig_q;
		cons_n  = cons_q;
		given_n = given_q || emit;
		if (chars.line_end) begin
			phase_n = tts_pkg::PH_FIELD_START;
			fcnt_n  = '0;
			dcnt_n  = '0;
			fv_n    = '{default: '0};
			facc_n  = '0;
			fdig_n  = '0;
			cons_n  = '0;
			given_n = 1'b0;
		end else if (!given_q && cons_q < CNT_W'(MAX_LINE_LEN)) begin
			unique case (phase_q)
				tts_pkg::PH_FIELD_START: begin
					if (is_digit) begin
						phase_n = tts_pkg::PH_IN_FIELD;
						fv_n[k] = FW'(dval);
						dcnt_n  = DC_W'(1);
						cons_n  = cons_q + CNT_W'(1);
					end
				end
				tts_pkg::PH_IN_FIELD: begin
					if (is_digit) begin
						if (dcnt_q < DC_W'(FIELD_DIGITS)) begin
							fv_n[k] = FW'((fv_q[k] << 3) + (fv_q[k] << 1) + FW'(dval));
							dcnt_n  = dcnt_q + DC_W'(1);
							cons_n  = cons_q + CNT_W'(1);
						end
					end else begin
						fcnt_n = fc1;
						if (fc1 < 2'd3 && chars.text_byte == tts_pkg::CH_COLON) begin
							cons_n  = cons_q + CNT_W'(1);
							phase_n = tts_pkg::PH_FIELD_START;
							dcnt_n  = '0;
						end else if (is_mark) begin
							cons_n  = cons_q + CNT_W'(1);
							phase_n = tts_pkg::PH_FRAC_START;
						end
					end
				end
				tts_pkg::PH_FRAC_START, tts_pkg::PH_IN_FRAC: begin
					if (is_digit) begin
						phase_n = tts_pkg::PH_IN_FRAC;
						if (fdig_q < NW'(FRAC_DIGITS)) begin
							facc_n = AW'((facc_q << 3) + (facc_q << 1) + AW'(dval));
							fdig_n = fdig_q + NW'(1);
						end
						cons_n = cons_q + CNT_W'(1);
					end
				end
			endcase
		end
	end

	// Verdict decision: fail code, or a finish that still checks the ranges.
	always_comb begin
		emit    = 1'b0;
		fin     = 1'b0;
		three   = fcnt_q == 2'd3;
		fail_st = tts_pkg::ST_OK;
		if (chars.line_end) begin
			if (!given_q) begin
				emit = 1'b1;
				unique case (phase_q)
					tts_pkg::PH_FIELD_START: fail_st = tts_pkg::ST_BAD_FIELD;
					tts_pkg::PH_IN_FIELD: begin
						if (fcnt_q == 2'd0) begin
							fail_st = tts_pkg::ST_SINGLE;
						end else begin
							fin   = 1'b1;
							three = fc1 == 2'd3;
						end
					end
					tts_pkg::PH_FRAC_START: fail_st = tts_pkg::ST_BAD_TERM;
					tts_pkg::PH_IN_FRAC:    fin = 1'b1;
				endcase
			end
		end else if (!given_q) begin
			if (cons_q >= CNT_W'(MAX_LINE_LEN)) begin
				emit    = 1'b1;
				fail_st = tts_pkg::ST_OVERLONG;
			end else begin
				unique case (phase_q)
					tts_pkg::PH_FIELD_START: begin
						if (!is_digit) begin
							emit    = 1'b1;
							fail_st = tts_pkg::ST_BAD_FIELD;
						end
					end
					tts_pkg::PH_IN_FIELD: begin
						if (is_digit) begin
							if (dcnt_q >= DC_W'(FIELD_DIGITS)) begin
								emit    = 1'b1;
								fail_st = tts_pkg::ST_BAD_FIELD;
							end
						end else if (fc1 < 2'd3 && chars.text_byte == tts_pkg::CH_COLON) begin
							emit = 1'b0;
						end else if (fc1 < 2'd2) begin
							emit    = 1'b1;
							fail_st = tts_pkg::ST_SINGLE;
						end else if (!is_mark) begin
							emit  = 1'b1;
							three = fc1 == 2'd3;
							if (is_blank) begin
								fin = 1'b1;
							end else begin
								fail_st = tts_pkg::ST_BAD_TERM;
							end
						end
					end
					tts_pkg::PH_FRAC_START: begin
						if (!is_digit) begin
							emit    = 1'b1;
							fail_st = tts_pkg::ST_BAD_TERM;
						end
					end
					tts_pkg::PH_IN_FRAC: begin
						if (!is_digit) begin
							emit = 1'b1;
							if (is_blank) begin
								fin = 1'b1;
							end else begin
								fail_st = tts_pkg::ST_BAD_TERM;
							end
						end
					end
				endcase
			end
		end
	end

	// Build the queue entry; range checks run minutes before seconds.
	logic [FW-1:0]          h, m, s;
	tts_pkg::status_t       st;
	logic [CNT_W+tts_pkg::USED_W-1:0] cons_wide;

	assign cons_wide = {{tts_pkg::USED_W{1'b0}}, cons_q};

	always_comb begin
		h = three ? fv_q[0] : '0;
		m = three ? fv_q[1] : fv_q[0];
		s = three ? fv_q[2] : fv_q[1];
		priority if (!fin)                                   st = fail_st;
		else if (three && m >= tts_pkg::SEXA_LIMIT)          st = tts_pkg::ST_MIN;
		else if (s >= tts_pkg::SEXA_LIMIT)                   st = tts_pkg::ST_SEC;
		else                                                 st = tts_pkg::ST_OK;
		entry.status = st;
		if (st == tts_pkg::ST_OK) begin
			entry.used        = cons_wide[tts_pkg::USED_W-1:0];
			entry.hours       = h;
			entry.minutes     = m;
			entry.seconds     = s;
			entry.frac        = facc_q;
			entry.frac_digits = fdig_q;
		end else begin
			entry.used        = '0;
			entry.hours       = '0;
			entry.minutes     = '0;
			entry.seconds     = '0;
			entry.frac        = '0;
			entry.frac_digits = '0;
		end
	end

	assign push = xfer && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tts_pkg::PH_FIELD_START;
			fcnt_q  <= '0;
			dcnt_q  <= '0;
			fv_q    <= '{default: '0};
			facc_q  <= '0;
			fdig_q  <= '0;
			cons_q  <= '0;
			given_q <= 1'b0;
		end else if (xfer) begin
			phase_q <= phase_n;
			fcnt_q  <= fcnt_n;
			dcnt_q  <= dcnt_n;
			fv_q    <= fv_n;
			facc_q  <= facc_n;
			fdig_q  <= fdig_n;
			cons_q  <= cons_n;
			given_q <= given_n;
		end
	end

endmodule

### design/tts_queue.sv
// Verdict queue of the timestamp text scanner: a short register ring between
// front and back. Depends on tts_pkg for the entry type and depth.
module tts_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  tts_pkg::verdict_t push_entry,
	output logic              full,
	input  logic              pop,
	output logic              valid,
	output tts_pkg::verdict_t head
);

	localparam int DEPTH = tts_pkg::QUEUE_DEPTH;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);

	tts_pkg::verdict_t mem_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]     count_q;

	assign full  = count_q == CW'(DEPTH);
	assign valid = count_q != '0;
	assign head  = mem_q[rd_ptr_q];

	function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### design/tts_back.sv
// Back of the timestamp text scanner: a four-stage multiply-accumulate pipeline
// that turns a verdict into microseconds. Depends on tts_pkg and tts_out_if.
module tts_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  tts_pkg::verdict_t q_head,
	output logic              q_pop,
	tts_out_if.source         verdicts
);

	localparam int TW = tts_pkg::TIME_W;

	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	tts_pkg::verdict_t vd_s1, vd_s2, vd_s3;
	logic [TW-1:0]     acc_s1, acc_s2, acc_s3, acc_s4;
	tts_pkg::status_t  st_s4;
	logic [tts_pkg::USED_W-1:0] used_s4;

	// Advance a stage when it is empty or the one after it advances.
	assign en_s4 = !v_s4 || verdicts.ready;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign q_pop = q_valid && en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= q_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && q_valid) begin
			vd_s1  <= q_head;
			acc_s1 <= TW'(q_head.hours) * TW'(tts_pkg::HOUR_US);
		end
		if (en_s2 && v_s1) begin
			vd_s2  <= vd_s1;
			acc_s2 <= acc_s1 + TW'(vd_s1.minutes) * TW'(tts_pkg::MIN_US);
		end
		if (en_s3 && v_s2) begin
			vd_s3  <= vd_s2;
			acc_s3 <= acc_s2 + TW'(vd_s2.seconds) * TW'(tts_pkg::SEC_US);
		end
		if (en_s4 && v_s3) begin
			st_s4   <= vd_s3.status;
			used_s4 <= vd_s3.used;
			acc_s4  <= acc_s3 + TW'(vd_s3.frac) * TW'(tts_pkg::frac_scale(vd_s3.frac_digits));
		end
	end

	assign verdicts.valid       = v_s4;
	assign verdicts.status      = st_s4;
	assign verdicts.used_length = used_s4;
	assign verdicts.time_us     = acc_s4;

endmodule

### design/timestamp_text_scanner.sv
// Timestamp text scanner: top level, joins front parser, verdict queue and
// time pipeline. Depends on tts_pkg, tts_in_if, tts_out_if and the tts modules.
//
// Feed a line one character per transfer on chars, then one transfer with
// line_end set; the block gives exactly one verdict per line on verdicts:
// a status, the number of characters the leading M:SS or H:MM:SS[.frac]
// timestamp used, and its start in microseconds. The verdict is pushed at the
// transfer that decides it (a bad character, the blank after the timestamp, the
// line end or a character beyond MAX_LINE_LEN); characters after that are
// swallowed until line_end. The front takes one character every cycle; its only
// throttle is the two-entry verdict queue, which fills only when the consumer
// holds verdicts.ready low. A verdict passes from the queue through the four
// pipeline stages of the back, each doing one constant multiply and add
// (hours, minutes, seconds, fraction); the last stage drives the channel.
// No clearing pass is needed after reset.
module timestamp_text_scanner #(
	parameter int MAX_LINE_LEN = tts_pkg::MAX_LINE_LEN_DEF,
	parameter int FIELD_DIGITS = tts_pkg::FIELD_DIGITS_DEF,
	parameter int FRAC_DIGITS  = tts_pkg::FRAC_DIGITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	tts_in_if.sink    chars,
	tts_out_if.source verdicts
);

	logic              push;
	logic              q_full;
	logic              q_valid;
	logic              q_pop;
	tts_pkg::verdict_t push_entry;
	tts_pkg::verdict_t q_head;

	// Parse characters and decide the verdict of each line.
	tts_front #(
		.MAX_LINE_LEN(MAX_LINE_LEN),
		.FIELD_DIGITS(FIELD_DIGITS),
		.FRAC_DIGITS (FRAC_DIGITS)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.chars (chars),
		.q_full(q_full),
		.push  (push),
		.entry (push_entry)
	);

	// Hold decided verdicts while the back or the consumer stalls.
	tts_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.head      (q_head)
	);

	// Convert fields to microseconds and drive the verdict channel.
	tts_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.verdicts(verdicts)
	);

	// Never push a verdict into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("verdict pushed into full queue");

	// A failed verdict carries neither a length nor a time.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(verdicts.valid && verdicts.status != tts_pkg::ST_OK) |->
		(verdicts.used_length == '0 && verdicts.time_us == '0))
		else $error("failed verdict with nonzero length or time");

	// Never pop an empty queue.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("verdict queue popped while empty");

endmodule
